/* design/rtprs_pkg.sv */
// Package: shared types and constants for the RTP receiver statistics core.
`timescale 1ns / 1ps
`default_nettype none

package rtprs_pkg;

   localparam int WINDOW_BITS_DEF = 1024;
   localparam int WORD_BITS       = 32;

   localparam logic [31:0] JIT_ROUND = 32'd8;
   localparam logic [31:0] JIT_SAT   = 32'hFFFF_FFFF;

   typedef enum logic [2:0] {
      CLS_FIRST     = 3'd0,
      CLS_ADVANCE   = 3'd1,
      CLS_DUPLICATE = 3'd2,
      CLS_REORDER   = 3'd3,
      CLS_TOO_LATE  = 3'd4,
      CLS_IGNORED   = 3'd5
   } pkt_class_type;

   typedef enum logic [4:0] {
      ST_INIT,
      ST_IDLE,
      ST_CHECK,
      ST_TRANSIT,
      ST_DELTA,
      ST_ABS,
      ST_RND,
      ST_DECAY,
      ST_JADD,
      ST_PEAK,
      ST_SEQ,
      ST_WIPE,
      ST_SKIP_RD,
      ST_SKIP_WR,
      ST_MARK_RD,
      ST_MARK_WR,
      ST_EXP1,
      ST_EXP2,
      ST_LOST1,
      ST_LOST2,
      ST_DONE
   } state_type;

   // operation for the shared adder: a + b, or a - b when sub is set
   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic        sub;
   } alu_req_type;

endpackage

`default_nettype wire

/* design/rtprs_if.sv */
// Interfaces: packet request channel and statistics response channel.
`timescale 1ns / 1ps
`default_nettype none

interface rtprs_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] seq_num;
   logic [31:0] media_ts;
   logic [31:0] source_id;
   logic [31:0] arrival_time;

   modport source (
      output valid, seq_num, media_ts, source_id, arrival_time,
      input  ready
   );
   modport sink (
      input  valid, seq_num, media_ts, source_id, arrival_time,
      output ready
   );
endinterface

interface rtprs_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         pkt_class;
   logic [31:0]        received_count;
   logic [31:0]        duplicate_count;
   logic [31:0]        reorder_count;
   logic [31:0]        too_late_count;
   logic [31:0]        ignored_count;
   logic [31:0]        expected_count;
   logic signed [31:0] lost_count;
   logic [31:0]        jitter_q4;
   logic [31:0]        jitter_peak_q4;

   modport source (
      output valid, pkt_class, received_count, duplicate_count, reorder_count,
             too_late_count, ignored_count, expected_count, lost_count,
             jitter_q4, jitter_peak_q4,
      input  ready
   );
   modport sink (
      input  valid, pkt_class, received_count, duplicate_count, reorder_count,
             too_late_count, ignored_count, expected_count, lost_count,
             jitter_q4, jitter_peak_q4,
      output ready
   );
endinterface

`default_nettype wire

/* design/rtp_receiver_stats_core.sv */
// Top level: RTP receiver statistics, sequence window and interarrival jitter.
//
//   channel | dir | handshake        | payload
//   --------+-----+------------------+--------------------------------------------
//   req     | in  | req.valid/ready  | seq_num, media_ts, source_id, arrival_time
//   rsp     | out | rsp.valid/ready  | pkt_class, counters, expected, lost, jitter
//
// One packet at a time: the accept step, 13 sequencer steps (ignored packets: 5,
// 11 and 4 of them on the shared adder; the first packet skips ST_ABS to ST_SEQ)
// and the output step; the seen map RAM adds a read and a write step for the mark,
// a read and a write step per touched word for skipped positions (at most
// WINDOW_BITS/32+1 words) or one write per word for a full wipe.
// After reset a clearing pass over all WINDOW_BITS/32 map words runs before req.ready.
// A finished result waits in the output register; the next packet is taken
// meanwhile and holds in its last step until rsp is free.
// WINDOW_BITS must be a power of two.
`timescale 1ns / 1ps
`default_nettype none

module rtp_receiver_stats_core #(
   parameter int WINDOW_BITS = rtprs_pkg::WINDOW_BITS_DEF
) (
   input wire logic    clock,
   input wire logic    reset,
   rtprs_req_if.sink   req,
   rtprs_rsp_if.source rsp
);
   import rtprs_pkg::*;

   localparam int POS_W     = $clog2(WINDOW_BITS);
   localparam int REM_W     = POS_W + 1;
   localparam int MAP_WORDS = WINDOW_BITS / WORD_BITS;
   localparam int ADDR_W    = (POS_W > 5) ? POS_W - 5 : 1;
   localparam int RAM_DEPTH = 1 << ADDR_W;
   localparam logic [ADDR_W-1:0] WORD_LAST = ADDR_W'(MAP_WORDS - 1);

   // control and statistics state
   state_type     state_ff, state_in;
   logic          locked_ff, locked_in;
   logic [31:0]   src_lock_ff, src_lock_in;
   logic [15:0]   base_ff, base_in;
   logic [15:0]   highest_ff, highest_in;
   logic [15:0]   wrap_ff, wrap_in;
   logic [31:0]   prev_ff, prev_in;
   logic [31:0]   jit_ff, jit_in;
   logic [31:0]   peak_ff, peak_in;
   logic [31:0]   recv_ff, recv_in;
   logic [31:0]   dup_ff, dup_in;
   logic [31:0]   reord_ff, reord_in;
   logic [31:0]   late_ff, late_in;
   logic [31:0]   ign_ff, ign_in;
   logic [ADDR_W-1:0] word_cnt_ff, word_cnt_in;
   logic          first_ff, first_in;
   logic          test_ff, test_in;
   logic          out_valid_ff, out_valid_in;

   // working registers
   logic [15:0]   seq_ff, seq_in;
   logic [31:0]   ts_ff, ts_in;
   logic [31:0]   src_ff, src_in;
   logic [31:0]   arr_ff, arr_in;
   logic [31:0]   transit_ff, transit_in;
   logic [31:0]   d_ff, d_in;
   logic [32:0]   t_ff, t_in;
   logic [31:0]   exp_ff, exp_in;
   logic [31:0]   lost_ff, lost_in;
   pkt_class_type cls_ff, cls_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [REM_W-1:0] rem_ff, rem_in;

   // output register
   pkt_class_type out_cls_ff, out_cls_in;
   logic [31:0]   out_recv_ff, out_recv_in;
   logic [31:0]   out_dup_ff, out_dup_in;
   logic [31:0]   out_reord_ff, out_reord_in;
   logic [31:0]   out_late_ff, out_late_in;
   logic [31:0]   out_ign_ff, out_ign_in;
   logic [31:0]   out_exp_ff, out_exp_in;
   logic [31:0]   out_lost_ff, out_lost_in;
   logic [31:0]   out_jit_ff, out_jit_in;
   logic [31:0]   out_peak_ff, out_peak_in;

   alu_req_type   alu_op;
   logic [32:0]   alu_res;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [31:0]       ram_wdata;
   logic [ADDR_W-1:0] ram_raddr;
   logic [31:0]       ram_rdata;

   logic [15:0]      seq_dist;
   logic [15:0]      lag;
   logic             dist_big;
   logic             lag_big;
   logic [POS_W-1:0] seq_pos;
   logic [ADDR_W-1:0] seq_word;
   logic [ADDR_W-1:0] pos_word;
   logic [31:0]      seq_bit;
   logic [4:0]       lo;
   logic [5:0]       room;
   logic [5:0]       skip_n;
   logic [5:0]       hi;
   logic [31:0]      clr_mask;
   logic [REM_W-1:0] rem_next;

   rtprs_alu u_alu (
      .op     (alu_op),
      .result (alu_res)
   );

   rtprs_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (RAM_DEPTH)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // sequence window helpers
   always_comb begin
      seq_dist = seq_ff - highest_ff;
      lag      = 16'd0 - seq_dist;
      dist_big = (seq_dist >> POS_W) != 16'd0;
      lag_big  = (lag >> POS_W) != 16'd0;
      seq_pos  = seq_ff[POS_W-1:0];
      seq_word = ADDR_W'(seq_pos >> 5);
      pos_word = ADDR_W'(pos_ff >> 5);
      seq_bit  = 32'd1 << seq_pos[4:0];
   end

   // clear mask for the skipped positions inside the current word
   always_comb begin
      lo     = pos_ff[4:0];
      room   = 6'd32 - {1'b0, lo};
      skip_n = (rem_ff < REM_W'(room)) ? rem_ff[5:0] : room;
      hi     = {1'b0, lo} + skip_n;
      for (int i = 0; i < 32; i++) begin
         clr_mask[i] = (6'(i) >= {1'b0, lo}) && (6'(i) < hi);
      end
      rem_next = rem_ff - REM_W'(skip_n);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         locked_ff    <= 1'b0;
         src_lock_ff  <= '0;
         base_ff      <= '0;
         highest_ff   <= '0;
         wrap_ff      <= '0;
         prev_ff      <= '0;
         jit_ff       <= '0;
         peak_ff      <= '0;
         recv_ff      <= '0;
         dup_ff       <= '0;
         reord_ff     <= '0;
         late_ff      <= '0;
         ign_ff       <= '0;
         word_cnt_ff  <= '0;
         first_ff     <= 1'b0;
         test_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         locked_ff    <= locked_in;
         src_lock_ff  <= src_lock_in;
         base_ff      <= base_in;
         highest_ff   <= highest_in;
         wrap_ff      <= wrap_in;
         prev_ff      <= prev_in;
         jit_ff       <= jit_in;
         peak_ff      <= peak_in;
         recv_ff      <= recv_in;
         dup_ff       <= dup_in;
         reord_ff     <= reord_in;
         late_ff      <= late_in;
         ign_ff       <= ign_in;
         word_cnt_ff  <= word_cnt_in;
         first_ff     <= first_in;
         test_ff      <= test_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      seq_ff       <= seq_in;
      ts_ff        <= ts_in;
      src_ff       <= src_in;
      arr_ff       <= arr_in;
      transit_ff   <= transit_in;
      d_ff         <= d_in;
      t_ff         <= t_in;
      exp_ff       <= exp_in;
      lost_ff      <= lost_in;
      cls_ff       <= cls_in;
      pos_ff       <= pos_in;
      rem_ff       <= rem_in;
      out_cls_ff   <= out_cls_in;
      out_recv_ff  <= out_recv_in;
      out_dup_ff   <= out_dup_in;
      out_reord_ff <= out_reord_in;
      out_late_ff  <= out_late_in;
      out_ign_ff   <= out_ign_in;
      out_exp_ff   <= out_exp_in;
      out_lost_ff  <= out_lost_in;
      out_jit_ff   <= out_jit_in;
      out_peak_ff  <= out_peak_in;
   end

   always_comb begin
      state_in     = state_ff;
      locked_in    = locked_ff;
      src_lock_in  = src_lock_ff;
      base_in      = base_ff;
      highest_in   = highest_ff;
      wrap_in      = wrap_ff;
      prev_in      = prev_ff;
      jit_in       = jit_ff;
      peak_in      = peak_ff;
      recv_in      = recv_ff;
      dup_in       = dup_ff;
      reord_in     = reord_ff;
      late_in      = late_ff;
      ign_in       = ign_ff;
      word_cnt_in  = word_cnt_ff;
      first_in     = first_ff;
      test_in      = test_ff;
      out_valid_in = out_valid_ff && !rsp.ready;

      seq_in       = seq_ff;
      ts_in        = ts_ff;
      src_in       = src_ff;
      arr_in       = arr_ff;
      transit_in   = transit_ff;
      d_in         = d_ff;
      t_in         = t_ff;
      exp_in       = exp_ff;
      lost_in      = lost_ff;
      cls_in       = cls_ff;
      pos_in       = pos_ff;
      rem_in       = rem_ff;

      out_cls_in   = out_cls_ff;
      out_recv_in  = out_recv_ff;
      out_dup_in   = out_dup_ff;
      out_reord_in = out_reord_ff;
      out_late_in  = out_late_ff;
      out_ign_in   = out_ign_ff;
      out_exp_in   = out_exp_ff;
      out_lost_in  = out_lost_ff;
      out_jit_in   = out_jit_ff;
      out_peak_in  = out_peak_ff;

      alu_op       = '{a: 32'd0, b: 32'd0, sub: 1'b0};
      ram_we       = 1'b0;
      ram_waddr    = pos_word;
      ram_wdata    = 32'd0;
      ram_raddr    = pos_word;
      req.ready    = 1'b0;

      case (state_ff)
         ST_INIT: begin
            ram_we      = 1'b1;
            ram_waddr   = word_cnt_ff;
            ram_wdata   = 32'd0;
            word_cnt_in = word_cnt_ff + ADDR_W'(1);
            if (word_cnt_ff == WORD_LAST) begin
               word_cnt_in = '0;
               state_in    = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               seq_in   = req.seq_num;
               ts_in    = req.media_ts;
               src_in   = req.source_id;
               arr_in   = req.arrival_time;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            test_in = 1'b0;
            if (!locked_ff) begin
               locked_in   = 1'b1;
               src_lock_in = src_ff;
               base_in     = seq_ff;
               highest_in  = seq_ff;
               wrap_in     = '0;
               recv_in     = 32'd1;
               cls_in      = CLS_FIRST;
               first_in    = 1'b1;
               state_in    = ST_TRANSIT;
            end else if (src_ff != src_lock_ff) begin
               ign_in   = ign_ff + 32'd1;
               cls_in   = CLS_IGNORED;
               state_in = ST_EXP1;
            end else begin
               recv_in  = recv_ff + 32'd1;
               first_in = 1'b0;
               state_in = ST_TRANSIT;
            end
         end
         ST_TRANSIT: begin
            alu_op     = '{a: arr_ff, b: ts_ff, sub: 1'b1};
            transit_in = alu_res[31:0];
            state_in   = ST_DELTA;
         end
         ST_DELTA: begin
            alu_op   = '{a: transit_ff, b: prev_ff, sub: 1'b1};
            d_in     = alu_res[31:0];
            prev_in  = transit_ff;
            // the first packet only seeds the transit reference
            state_in = first_ff ? ST_MARK_RD : ST_ABS;
         end
         ST_ABS: begin
            alu_op = '{a: 32'd0, b: d_ff, sub: 1'b1};
            if (d_ff[31]) begin
               d_in = alu_res[31:0];
            end
            state_in = ST_RND;
         end
         ST_RND: begin
            alu_op   = '{a: jit_ff, b: JIT_ROUND, sub: 1'b0};
            t_in     = alu_res;
            state_in = ST_DECAY;
         end
         ST_DECAY: begin
            alu_op   = '{a: jit_ff, b: 32'(t_ff[32:4]), sub: 1'b1};
            t_in     = alu_res;
            state_in = ST_JADD;
         end
         ST_JADD: begin
            alu_op   = '{a: t_ff[31:0], b: d_ff, sub: 1'b0};
            jit_in   = alu_res[32] ? JIT_SAT : alu_res[31:0];
            state_in = ST_PEAK;
         end
         ST_PEAK: begin
            alu_op = '{a: peak_ff, b: jit_ff, sub: 1'b1};
            if (!alu_res[32]) begin
               peak_in = jit_ff;
            end
            state_in = ST_SEQ;
         end
         ST_SEQ: begin
            if (seq_dist == 16'd0) begin
               dup_in   = dup_ff + 32'd1;
               cls_in   = CLS_DUPLICATE;
               state_in = ST_EXP1;
            end else if (!seq_dist[15]) begin
               cls_in     = CLS_ADVANCE;
               highest_in = seq_ff;
               if (seq_ff < highest_ff) begin
                  wrap_in = wrap_ff + 16'd1;
               end
               pos_in = highest_ff[POS_W-1:0] + POS_W'(1);
               rem_in = REM_W'(seq_dist - 16'd1);
               if (dist_big) begin
                  word_cnt_in = '0;
                  state_in    = ST_WIPE;
               end else if (seq_dist == 16'd1) begin
                  state_in = ST_MARK_RD;
               end else begin
                  state_in = ST_SKIP_RD;
               end
            end else if (lag_big) begin
               late_in  = late_ff + 32'd1;
               cls_in   = CLS_TOO_LATE;
               state_in = ST_EXP1;
            end else begin
               test_in  = 1'b1;
               state_in = ST_MARK_RD;
            end
         end
         ST_WIPE: begin
            ram_we      = 1'b1;
            ram_waddr   = word_cnt_ff;
            ram_wdata   = 32'd0;
            word_cnt_in = word_cnt_ff + ADDR_W'(1);
            if (word_cnt_ff == WORD_LAST) begin
               word_cnt_in = '0;
               state_in    = ST_MARK_RD;
            end
         end
         ST_SKIP_RD: begin
            ram_raddr = pos_word;
            state_in  = ST_SKIP_WR;
         end
         ST_SKIP_WR: begin
            ram_we    = 1'b1;
            ram_waddr = pos_word;
            ram_wdata = ram_rdata & ~clr_mask;
            pos_in    = pos_ff + POS_W'(skip_n);
            rem_in    = rem_next;
            state_in  = (rem_next == '0) ? ST_MARK_RD : ST_SKIP_RD;
         end
         ST_MARK_RD: begin
            ram_raddr = seq_word;
            state_in  = ST_MARK_WR;
         end
         ST_MARK_WR: begin
            ram_we    = 1'b1;
            ram_waddr = seq_word;
            ram_wdata = ram_rdata | seq_bit;
            if (test_ff) begin
               if ((ram_rdata & seq_bit) != 32'd0) begin
                  dup_in = dup_ff + 32'd1;
                  cls_in = CLS_DUPLICATE;
               end else begin
                  reord_in = reord_ff + 32'd1;
                  cls_in   = CLS_REORDER;
               end
            end
            state_in = ST_EXP1;
         end
         ST_EXP1: begin
            alu_op   = '{a: {wrap_ff, highest_ff}, b: {16'd0, base_ff}, sub: 1'b1};
            t_in     = alu_res;
            state_in = ST_EXP2;
         end
         ST_EXP2: begin
            alu_op   = '{a: t_ff[31:0], b: 32'd1, sub: 1'b0};
            exp_in   = alu_res[31:0];
            state_in = ST_LOST1;
         end
         ST_LOST1: begin
            alu_op   = '{a: recv_ff, b: dup_ff, sub: 1'b1};
            t_in     = alu_res;
            state_in = ST_LOST2;
         end
         ST_LOST2: begin
            alu_op   = '{a: exp_ff, b: t_ff[31:0], sub: 1'b1};
            lost_in  = alu_res[31:0];
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!out_valid_ff || rsp.ready) begin
               out_valid_in = 1'b1;
               out_cls_in   = cls_ff;
               out_recv_in  = recv_ff;
               out_dup_in   = dup_ff;
               out_reord_in = reord_ff;
               out_late_in  = late_ff;
               out_ign_in   = ign_ff;
               out_exp_in   = exp_ff;
               out_lost_in  = lost_ff;
               out_jit_in   = jit_ff;
               out_peak_in  = peak_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp.valid           = out_valid_ff;
   assign rsp.pkt_class       = out_cls_ff;
   assign rsp.received_count  = out_recv_ff;
   assign rsp.duplicate_count = out_dup_ff;
   assign rsp.reorder_count   = out_reord_ff;
   assign rsp.too_late_count  = out_late_ff;
   assign rsp.ignored_count   = out_ign_ff;
   assign rsp.expected_count  = out_exp_ff;
   assign rsp.lost_count      = $signed(out_lost_ff);
   assign rsp.jitter_q4       = out_jit_ff;
   assign rsp.jitter_peak_q4  = out_peak_ff;

endmodule

`default_nettype wire

/* design/rtprs_ram.sv */
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module rtprs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

/* design/rtprs_alu.sv */
// Shared 32-bit adder/subtractor with carry out, used by the arithmetic sequencer steps.
`timescale 1ns / 1ps
`default_nettype none

module rtprs_alu (
   input  wire rtprs_pkg::alu_req_type op,
   output logic [32:0]                 result
);
   import rtprs_pkg::*;

   logic [31:0] b_eff;

   // for a subtract, carry out set means a >= b
   assign b_eff  = op.sub ? ~op.b : op.b;
   assign result = {1'b0, op.a} + {1'b0, b_eff} + {32'd0, op.sub};

endmodule

`default_nettype wire

/* tb/tb.sv */
// Testbench for rtp_receiver_stats_core: packet stream stimulus, statistics predictor, checks.
`timescale 1ns / 1ps

module tb;
   import rtprs_pkg::*;

   localparam int WIN         = WINDOW_BITS_DEF;
   localparam int CYCLE_LIMIT = 500000;
   localparam int TAIL_CYCLES = 200;
   localparam int QUIET_TAIL  = 120;
   localparam logic [31:0] SRC_LOCK = 32'h6B2E_91D4;

   typedef struct packed {
      logic [15:0] seq;
      logic [31:0] ts;
      logic [31:0] src;
      logic [31:0] arr;
   } rtp_pkt_type;

   typedef struct packed {
      pkt_class_type cls;
      logic [31:0]   recv;
      logic [31:0]   dups;
      logic [31:0]   reord;
      logic [31:0]   late;
      logic [31:0]   ign;
      logic [31:0]   expct;
      logic [31:0]   lost;
      logic [31:0]   jit;
      logic [31:0]   peak;
   } stats_type;

   logic clock;
   logic reset;

   rtprs_req_if req ();
   rtprs_rsp_if rsp ();

   rtp_receiver_stats_core dut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp)
   );

   rtp_pkt_type pkt_backlog[$];
   stats_type   stats_due[$];

   int pkts_taken  = 0;
   int rsps_taken  = 0;
   int total_pkts  = 0;
   int mismatches  = 0;
   int cycles      = 0;
   int send_gap    = 0;
   int stall_left  = 0;

   // receiver state as the block should hold it
   logic           st_locked  = 1'b0;
   logic [31:0]    st_source  = '0;
   logic [15:0]    st_base    = '0;
   logic [15:0]    st_top     = '0;
   logic [15:0]    st_wraps   = '0;
   logic [31:0]    st_transit = '0;
   logic [31:0]    st_jitter  = '0;
   logic [31:0]    st_peak    = '0;
   logic [31:0]    st_recv    = '0;
   logic [31:0]    st_dups    = '0;
   logic [31:0]    st_reord   = '0;
   logic [31:0]    st_late    = '0;
   logic [31:0]    st_ignored = '0;
   logic [WIN-1:0] seen_bits  = '0;

   // stimulus-side view of the highest sequence number
   logic        gen_locked = 1'b0;
   logic [15:0] gen_top    = '0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic stats_type account_packet(input rtp_pkt_type p);
      stats_type     r;
      pkt_class_type cls;
      logic [31:0]   transit;
      logic [31:0]   delta;
      logic [31:0]   expct;
      logic [33:0]   acc;
      logic [15:0]   seq_dist;
      logic [15:0]   lag;
      int            k;
      if (!st_locked) begin
         st_locked  = 1'b1;
         st_source  = p.src;
         st_base    = p.seq;
         st_top     = p.seq;
         st_wraps   = '0;
         st_recv    = 32'd1;
         seen_bits[p.seq % WIN] = 1'b1;
         st_transit = p.arr - p.ts;
         cls        = CLS_FIRST;
      end else if (p.src != st_source) begin
         st_ignored = st_ignored + 32'd1;
         cls        = CLS_IGNORED;
      end else begin
         st_recv = st_recv + 32'd1;
         transit = p.arr - p.ts;
         delta   = transit - st_transit;
         if (delta[31]) begin
            delta = 32'd0 - delta;
         end
         acc = {2'b00, st_jitter} - (({2'b00, st_jitter} + 34'd8) >> 4) + {2'b00, delta};
         st_jitter = (acc[33:32] != 2'b00) ? 32'hFFFF_FFFF : acc[31:0];
         if (st_jitter > st_peak) begin
            st_peak = st_jitter;
         end
         st_transit = transit;

         seq_dist = p.seq - st_top;
         if (seq_dist == 16'd0) begin
            st_dups = st_dups + 32'd1;
            cls     = CLS_DUPLICATE;
         end else if (!seq_dist[15]) begin
            if (p.seq < st_top) begin
               st_wraps = st_wraps + 16'd1;
            end
            if (seq_dist >= WIN) begin
               seen_bits = '0;
            end else begin
               for (k = 1; k < seq_dist; k++) begin
                  seen_bits[(st_top + k) % WIN] = 1'b0;
               end
            end
            seen_bits[p.seq % WIN] = 1'b1;
            st_top = p.seq;
            cls    = CLS_ADVANCE;
         end else begin
            lag = 16'd0 - seq_dist;
            if (lag >= WIN) begin
               st_late = st_late + 32'd1;
               cls     = CLS_TOO_LATE;
            end else if (seen_bits[p.seq % WIN]) begin
               st_dups = st_dups + 32'd1;
               cls     = CLS_DUPLICATE;
            end else begin
               st_reord = st_reord + 32'd1;
               seen_bits[p.seq % WIN] = 1'b1;
               cls      = CLS_REORDER;
            end
         end
      end

      expct   = {st_wraps, 16'h0000} + st_top - st_base + 32'd1;
      r.cls   = cls;
      r.recv  = st_recv;
      r.dups  = st_dups;
      r.reord = st_reord;
      r.late  = st_late;
      r.ign   = st_ignored;
      r.expct = expct;
      r.lost  = expct - (st_recv - st_dups);
      r.jit   = st_jitter;
      r.peak  = st_peak;
      return r;
   endfunction

   task automatic queue_pkt(input logic [15:0] seq, input logic [31:0] ts,
                            input logic [31:0] src, input logic [31:0] arr);
      rtp_pkt_type p;
      logic [15:0] seq_dist;
      p.seq = seq;
      p.ts  = ts;
      p.src = src;
      p.arr = arr;
      pkt_backlog.push_back(p);
      seq_dist = seq - gen_top;
      if (!gen_locked) begin
         gen_locked = 1'b1;
         gen_top    = seq;
      end else if (src == SRC_LOCK && seq_dist != 16'd0 && !seq_dist[15]) begin
         gen_top = seq;
      end
   endtask

   task automatic flag_mismatch(input string msg);
      $display("mismatch: %s", msg);
      mismatches++;
   endtask

   task automatic check_word(input string field, input logic [31:0] got,
                             input logic [31:0] want);
      if (got !== want) begin
         flag_mismatch($sformatf("response %0d %s got %h want %h",
                                 rsps_taken, field, got, want));
      end
   endtask

   // no idling near the end, and every fourth stretch runs flat out
   function automatic logic idle_window();
      return (pkts_taken < total_pkts - QUIET_TAIL) && ((pkts_taken / 90) % 4 != 3);
   endfunction

   initial begin
      logic [15:0] seq;
      logic [15:0] step;
      logic [31:0] ts;
      logic [31:0] src;
      logic [31:0] arr;
      logic [31:0] ts_clk;
      int          noise;
      int          pick;
      int          n;
      int          k;

      reset          = 1'b1;
      req.valid      = 1'b0;
      req.seq_num    = '0;
      req.media_ts   = '0;
      req.source_id  = '0;
      req.arrival_time = '0;
      rsp.ready      = 1'b0;

      // directed: lock, duplicates, wrap, window edges, wipe, ignored sources
      queue_pkt(16'hFFF0, 32'd0, SRC_LOCK, 32'd100);
      queue_pkt(16'hFFF0, 32'd160, SRC_LOCK, 32'd260);
      queue_pkt(16'hFFF1, 32'd320, SRC_LOCK, 32'd430);
      queue_pkt(16'h0000, 32'h0000_1234, 32'hFFFF_FFFF, 32'h0000_5678);
      queue_pkt(16'hFFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
      queue_pkt(16'h0005, 32'd640, SRC_LOCK, 32'd740);
      queue_pkt(16'hFFF5, 32'd800, SRC_LOCK, 32'd900);
      queue_pkt(16'hFFF5, 32'd960, SRC_LOCK, 32'd1060);
      queue_pkt(16'h0004, 32'd1120, SRC_LOCK, 32'd1220);
      queue_pkt(16'hFC05, 32'd1280, SRC_LOCK, 32'd1380);
      queue_pkt(16'hFC06, 32'd1440, SRC_LOCK, 32'd1540);
      queue_pkt(16'h0404, 32'd1600, SRC_LOCK, 32'd1700);
      queue_pkt(16'h0804, 32'd1760, SRC_LOCK, 32'd1860);
      queue_pkt(16'h0803, 32'd1920, SRC_LOCK, 32'd2020);
      queue_pkt(16'h8803, 32'd2080, SRC_LOCK, 32'd2180);
      queue_pkt(16'h0803, 32'd2240, SRC_LOCK, 32'd2340);
      // transit swings by half the range: drives jitter into saturation
      for (k = 0; k < 6; k++) begin
         ts = 32'd2400 + 32'd160 * k;
         queue_pkt(16'(16'h8804 + k), ts, SRC_LOCK,
                   ts + ((k % 2 == 0) ? 32'h8000_0000 : 32'd0));
      end
      queue_pkt(16'h880A, 32'hFFFF_FFFF, SRC_LOCK, 32'hFFFF_FFFF);
      queue_pkt(16'hFFFF, 32'h7FFF_FFFF, SRC_LOCK, 32'h0000_0000);
      queue_pkt(16'h0000, 32'h0000_0000, SRC_LOCK, 32'h8000_0001);

      // random stream: mostly a plausible flow with losses, reorders and jumps
      ts_clk = 32'hFFF0_0000;
      noise  = 0;
      n      = 0;
      while (n < 770) begin
         if ($urandom_range(0, 99) < 7) begin
            do begin
               src = $urandom;
            end while (src == SRC_LOCK);
            seq = 16'($urandom);
            queue_pkt(seq, $urandom, src, $urandom);
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
               step = 16'd1;
               seq  = gen_top + step;
            end else if (pick < 58) begin
               step = 16'($urandom_range(2, 40));
               seq  = gen_top + step;
            end else if (pick < 63) begin
               seq = gen_top;
            end else if (pick < 73) begin
               step = 16'($urandom_range(1, 40));
               seq  = gen_top - step;
            end else if (pick < 77) begin
               step = 16'($urandom_range(1000, 1050));
               seq  = gen_top - step;
            end else if (pick < 81) begin
               step = 16'($urandom_range(1024, 32768));
               seq  = gen_top - step;
            end else if (pick < 85) begin
               step = 16'($urandom_range(1000, 1100));
               seq  = gen_top + step;
            end else if (pick < 88) begin
               step = 16'($urandom_range(1100, 32767));
               seq  = gen_top + step;
            end else begin
               seq = 16'($urandom);
            end
            ts_clk = ts_clk + 32'd160;
            if ($urandom_range(0, 99) < 90) begin
               ts  = ts_clk;
               arr = ts_clk + 32'd4000 + $urandom_range(0, noise);
            end else begin
               ts  = $urandom;
               arr = $urandom;
            end
            queue_pkt(seq, ts, SRC_LOCK, arr);
            n++;
            case ((n / 100) % 4)
               0: noise = 0;
               1: noise = 40;
               2: noise = 3000;
               default: noise = 250000;
            endcase
         end
      end
      total_pkts = pkt_backlog.size();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (pkt_backlog.size() != 0 || req.valid || stats_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d packets sent, %0d responses",
                  cycles, pkts_taken, rsps_taken);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // packet driver
   always @(posedge clock) begin : drive_pkts
      rtp_pkt_type nxt;
      logic        nxt_valid;
      if (reset) begin
         req.valid <= 1'b0;
         send_gap  = 0;
      end else begin
         nxt_valid = req.valid;
         if (req.valid && req.ready) begin
            stats_due.push_back(account_packet({req.seq_num, req.media_ts,
                                                req.source_id, req.arrival_time}));
            pkts_taken++;
            nxt_valid = 1'b0;
         end
         if (!nxt_valid) begin
            if (send_gap != 0) begin
               send_gap--;
            end else if (pkt_backlog.size() != 0) begin
               nxt = pkt_backlog.pop_front();
               req.seq_num      <= nxt.seq;
               req.media_ts     <= nxt.ts;
               req.source_id    <= nxt.src;
               req.arrival_time <= nxt.arr;
               nxt_valid = 1'b1;
               // gap starts once this transaction is taken
               if (idle_window() && $urandom_range(0, 99) < 20) begin
                  send_gap = $urandom_range(1, 13);
               end
            end
         end
         req.valid <= nxt_valid;
      end
   end

   // response monitor and back-pressure
   always @(posedge clock) begin : watch_stats
      stats_type want;
      if (reset) begin
         rsp.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (stats_due.size() == 0) begin
               flag_mismatch($sformatf("response %0d with no packet outstanding",
                                       rsps_taken));
            end else begin
               want = stats_due.pop_front();
               check_word("pkt_class", 32'(rsp.pkt_class), 32'(want.cls));
               check_word("received_count", rsp.received_count, want.recv);
               check_word("duplicate_count", rsp.duplicate_count, want.dups);
               check_word("reorder_count", rsp.reorder_count, want.reord);
               check_word("too_late_count", rsp.too_late_count, want.late);
               check_word("ignored_count", rsp.ignored_count, want.ign);
               check_word("expected_count", rsp.expected_count, want.expct);
               check_word("lost_count", rsp.lost_count, want.lost);
               check_word("jitter_q4", rsp.jitter_q4, want.jit);
               check_word("jitter_peak_q4", rsp.jitter_peak_q4, want.peak);
            end
            rsps_taken++;
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp.ready <= 1'b0;
         end else if (idle_window() && $urandom_range(0, 99) < 6) begin
            stall_left = $urandom_range(0, 12);
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

endmodule
